@@ sv/lrupr_pkg.sv @@
// Shared types, widths and codes for the LRU page replacement list.
package lrupr_pkg;

	localparam int ENTRIES    = 16;
	localparam int PAGE_BITS  = 10;
	localparam int VADDR_BITS = 39;
	localparam int CNT_W      = $clog2(ENTRIES + 1);

	typedef logic [PAGE_BITS-1:0]  page_t;
	typedef logic [VADDR_BITS-1:0] vaddr_t;
	typedef logic [CNT_W-1:0]      cnt_t;
	typedef logic [1:0]            status_t;

	localparam status_t ST_DONE  = 2'd0;
	localparam status_t ST_FULL  = 2'd1;
	localparam status_t ST_EMPTY = 2'd2;

	localparam logic REQ_TOUCH = 1'b0;
	localparam logic REQ_EVICT = 1'b1;

	// Command broadcast to every cell of the list in the cycle of a transfer.
	typedef struct packed {
		logic   touch;
		logic   evict;
		page_t  page;
		vaddr_t vaddr;
	} cell_cmd_t;

	// Per-cell position decode produced by the list controller.
	typedef struct packed {
		logic occ;
		logic last;
		logic load;
	} cell_ctl_t;

endpackage

@@ sv/lrupr_if.sv @@
// Request and response channel interfaces of the LRU page replacement list.
interface lrupr_req_if;
	logic                 valid;
	logic                 ready;
	logic                 req_type;
	lrupr_pkg::page_t     page_id;
	lrupr_pkg::vaddr_t    vaddr;

	modport source (output valid, output req_type, output page_id, output vaddr, input ready);
	modport sink   (input valid, input req_type, input page_id, input vaddr, output ready);
endinterface

interface lrupr_rsp_if;
	logic                 valid;
	logic                 ready;
	lrupr_pkg::status_t   status;
	logic                 victim_valid;
	lrupr_pkg::page_t     victim_page;
	lrupr_pkg::vaddr_t    victim_vaddr;

	modport source (output valid, output status, output victim_valid, output victim_page,
		output victim_vaddr, input ready);
	modport sink   (input valid, input status, input victim_valid, input victim_page,
		input victim_vaddr, output ready);
endinterface

@@ sv/lrupr_cell.sv @@
// One slot of the recency list: holds a page and its address, shifts from its younger neighbor.
module lrupr_cell (
	input  logic                 clk,
	input  lrupr_pkg::cell_cmd_t cmd,
	input  lrupr_pkg::cell_ctl_t ctl,
	input  lrupr_pkg::page_t     next_page,
	input  lrupr_pkg::vaddr_t    next_vaddr,
	input  logic                 seen_in,
	output logic                 seen_out,
	output lrupr_pkg::page_t     page,
	output lrupr_pkg::vaddr_t    vaddr
);

	lrupr_pkg::page_t  page_q;
	lrupr_pkg::vaddr_t vaddr_q;
	logic              match;
	logic              shift;

	assign match    = ctl.occ && (page_q == cmd.page);
	assign seen_out = seen_in | match;

	// Every occupied slot at or after the removed one, but the last, pulls in its younger neighbor.
	assign shift = ctl.occ && !ctl.last && (cmd.evict || (cmd.touch && seen_out));

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			page_q  <= cmd.page;
			vaddr_q <= cmd.vaddr;
		end else if (shift) begin
			page_q  <= next_page;
			vaddr_q <= next_vaddr;
		end
	end

	assign page  = page_q;
	assign vaddr = vaddr_q;

endmodule

@@ sv/lru_page_replacement.sv @@
// Top level of the LRU page replacement list: cell chain, fill count and response register.
// The response to a request is registered and shown in the cycle after its transfer.
// Throughput: one request per cycle while responses are taken; the list updates in the
// same cycle through the cell chain's match and shift, so requests never wait on each other.
// Reset clears the fill count and the response valid; slot contents are not cleared and
// only slots below the fill count are ever read.
module lru_page_replacement (
	input  logic       clk,
	input  logic       arst_n,
	lrupr_req_if.sink  req,
	lrupr_rsp_if.source rsp
);

	localparam int N = lrupr_pkg::ENTRIES;

	lrupr_pkg::cnt_t      fill_q;
	lrupr_pkg::cnt_t      fill_next;
	lrupr_pkg::cell_cmd_t cmd;
	lrupr_pkg::cell_ctl_t ctl [N];
	lrupr_pkg::page_t     cell_page [N];
	lrupr_pkg::vaddr_t    cell_vaddr [N];
	logic [N:0]           seen;
	logic                 accept;
	logic                 found;
	logic                 full;
	logic                 empty;

	logic                 rsp_valid_q;
	lrupr_pkg::status_t   status_q;
	logic                 victim_valid_q;
	lrupr_pkg::page_t     victim_page_q;
	lrupr_pkg::vaddr_t    victim_vaddr_q;

	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;

	assign cmd.touch = accept && (req.req_type == lrupr_pkg::REQ_TOUCH);
	assign cmd.evict = accept && (req.req_type == lrupr_pkg::REQ_EVICT);
	assign cmd.page  = req.page_id;
	assign cmd.vaddr = req.vaddr;

	assign full  = (fill_q == lrupr_pkg::cnt_t'(N));
	assign empty = (fill_q == '0);

	assign seen[0] = 1'b0;
	assign found   = seen[N];

	for (genvar k = 0; k < N; k++) begin : g_cell
		logic             tail;
		lrupr_pkg::page_t  nb_page;
		lrupr_pkg::vaddr_t nb_vaddr;

		assign ctl[k].occ  = (fill_q > lrupr_pkg::cnt_t'(k));
		assign ctl[k].last = (fill_q == lrupr_pkg::cnt_t'(k + 1));
		assign tail        = (fill_q == lrupr_pkg::cnt_t'(k));
		// A listed page is rewritten at the young end; a new page goes to the first free slot.
		assign ctl[k].load = cmd.touch && ((found && ctl[k].last) || (!found && tail));

		if (k < N - 1) begin : g_mid
			assign nb_page  = cell_page[k+1];
			assign nb_vaddr = cell_vaddr[k+1];
		end else begin : g_end
			assign nb_page  = cell_page[k];
			assign nb_vaddr = cell_vaddr[k];
		end

		lrupr_cell u_cell (
			.clk       (clk),
			.cmd       (cmd),
			.ctl       (ctl[k]),
			.next_page (nb_page),
			.next_vaddr(nb_vaddr),
			.seen_in   (seen[k]),
			.seen_out  (seen[k+1]),
			.page      (cell_page[k]),
			.vaddr     (cell_vaddr[k])
		);
	end

	always_comb begin
		fill_next = fill_q;
		if (cmd.touch && !found && !full) begin
			fill_next = fill_q + lrupr_pkg::cnt_t'(1);
		end else if (cmd.evict && !empty) begin
			fill_next = fill_q - lrupr_pkg::cnt_t'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			fill_q <= fill_next;
			if (accept) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q       <= lrupr_pkg::ST_DONE;
			victim_valid_q <= 1'b0;
			victim_page_q  <= '0;
			victim_vaddr_q <= '0;
			if (cmd.touch && !found && full) begin
				status_q <= lrupr_pkg::ST_FULL;
			end
			if (cmd.evict) begin
				if (empty) begin
					status_q <= lrupr_pkg::ST_EMPTY;
				end else begin
					victim_valid_q <= 1'b1;
					victim_page_q  <= cell_page[0];
					victim_vaddr_q <= cell_vaddr[0];
				end
			end
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.status       = status_q;
	assign rsp.victim_valid = victim_valid_q;
	assign rsp.victim_page  = victim_page_q;
	assign rsp.victim_vaddr = victim_vaddr_q;

endmodule

@@ sv/lrupr_chk.sv @@
// Port-level checker for the LRU page replacement list, bound to the top level.
module lrupr_chk (
	input logic               clk,
	input logic               arst_n,
	input logic               req_valid,
	input logic               req_ready,
	input logic               rsp_valid,
	input logic               rsp_ready,
	input lrupr_pkg::status_t status,
	input logic               victim_valid,
	input lrupr_pkg::page_t   victim_page,
	input lrupr_pkg::vaddr_t  victim_vaddr
);

	// A transfer of a request always yields a response in the next cycle.
	a_rsp_follows: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> rsp_valid)
		else $error("request transfer not followed by a response");

	a_victim_done: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && victim_valid |-> status == lrupr_pkg::ST_DONE)
		else $error("victim returned with a failure status");

	a_no_victim_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !victim_valid |-> victim_page == '0 && victim_vaddr == '0)
		else $error("victim fields not zero without a victim");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(victim_valid)
			&& $stable(victim_page) && $stable(victim_vaddr))
		else $error("stalled response changed");

endmodule

bind lru_page_replacement lrupr_chk u_lrupr_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req.valid),
	.req_ready   (req.ready),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.status      (rsp.status),
	.victim_valid(rsp.victim_valid),
	.victim_page (rsp.victim_page),
	.victim_vaddr(rsp.victim_vaddr)
);

@@ test/lru_page_replacement_test.sv @@
// Testbench for the LRU page replacement list: random and directed requests checked against a predictor.
module lru_page_replacement_test;

	typedef struct packed {
		logic               req_type;
		lrupr_pkg::page_t   page_id;
		lrupr_pkg::vaddr_t  vaddr;
	} page_req_t;

	typedef struct packed {
		lrupr_pkg::status_t status;
		logic               victim_valid;
		lrupr_pkg::page_t   victim_page;
		lrupr_pkg::vaddr_t  victim_vaddr;
	} page_rsp_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	lrupr_req_if req_ch ();
	lrupr_rsp_if rsp_ch ();

	lru_page_replacement DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always #2 clk = ~clk;

	// Request and response side registers, known from time zero.
	logic      drv_valid = 1'b0;
	page_req_t drv_item = '0;
	logic      take_ready = 1'b0;

	assign req_ch.valid    = drv_valid;
	assign req_ch.req_type = drv_item.req_type;
	assign req_ch.page_id  = drv_item.page_id;
	assign req_ch.vaddr    = drv_item.vaddr;
	assign rsp_ch.ready    = take_ready;

	page_req_t pending_reqs[$];
	page_rsp_t due_rsps[$];
	int        mismatches = 0;
	int        rsp_count = 0;
	bit        long_hold_done = 1'b0;

	// Predicted list: slot 0 is the least recently touched page.
	lrupr_pkg::page_t  lru_page  [lrupr_pkg::ENTRIES];
	lrupr_pkg::vaddr_t lru_vaddr [lrupr_pkg::ENTRIES];
	int                lru_fill = 0;

	function automatic void lru_remove(int pos);
		for (int k = pos; k + 1 < lru_fill; k++) begin
			lru_page[k]  = lru_page[k + 1];
			lru_vaddr[k] = lru_vaddr[k + 1];
		end
		lru_fill--;
	endfunction

	function automatic page_rsp_t lru_apply(page_req_t r);
		page_rsp_t res;
		int hit;
		res = '0;
		res.status = lrupr_pkg::ST_DONE;
		hit = -1;
		if (r.req_type == lrupr_pkg::REQ_TOUCH) begin
			for (int k = 0; k < lru_fill; k++)
				if (hit < 0 && lru_page[k] == r.page_id)
					hit = k;
			if (hit >= 0)
				lru_remove(hit);
			if (lru_fill < lrupr_pkg::ENTRIES) begin
				lru_page[lru_fill]  = r.page_id;
				lru_vaddr[lru_fill] = r.vaddr;
				lru_fill++;
			end else begin
				res.status = lrupr_pkg::ST_FULL;
			end
		end else if (lru_fill == 0) begin
			res.status = lrupr_pkg::ST_EMPTY;
		end else begin
			res.victim_valid = 1'b1;
			res.victim_page  = lru_page[0];
			res.victim_vaddr = lru_vaddr[0];
			lru_remove(0);
		end
		return res;
	endfunction

	// Mostly back to back, some short gaps, a few long ones.
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(6, 25);
	endfunction

	int src_idle = 0;
	int src_calm = 0;

	always @(posedge clk or negedge arst_n) begin : req_driver
		logic fire;
		if (!arst_n) begin
			drv_valid <= 1'b0;
			drv_item  <= '0;
			src_idle  <= 0;
			src_calm  <= 0;
		end else begin
			fire = drv_valid && req_ch.ready;
			if (fire)
				due_rsps.push_back(lru_apply(drv_item));
			if (!drv_valid || fire) begin
				if (src_idle > 0) begin
					src_idle  <= src_idle - 1;
					drv_valid <= 1'b0;
				end else if (pending_reqs.size() != 0) begin
					drv_item  <= pending_reqs.pop_front();
					drv_valid <= 1'b1;
					if (src_calm > 0) begin
						src_calm <= src_calm - 1;
						src_idle <= 0;
					end else begin
						src_idle <= idle_len();
						if ($urandom_range(0, 49) == 0)
							src_calm <= $urandom_range(20, 60);
					end
				end else begin
					drv_valid <= 1'b0;
				end
			end
		end
	end

	int sink_stall = 0;
	int sink_calm = 0;

	always @(posedge clk or negedge arst_n) begin : rsp_monitor
		logic fire;
		page_rsp_t got;
		page_rsp_t want;
		int n;
		if (!arst_n) begin
			take_ready <= 1'b0;
			sink_stall <= 0;
			sink_calm  <= 0;
		end else begin
			fire = rsp_ch.valid && take_ready;
			if (fire) begin
				got.status       = rsp_ch.status;
				got.victim_valid = rsp_ch.victim_valid;
				got.victim_page  = rsp_ch.victim_page;
				got.victim_vaddr = rsp_ch.victim_vaddr;
				rsp_count = rsp_count + 1;
				if (due_rsps.size() == 0) begin
					mismatches = mismatches + 1;
					if (mismatches <= 10)
						$display("unexpected response: status %0d victim %0b page %0d vaddr %h",
							got.status, got.victim_valid, got.victim_page, got.victim_vaddr);
				end else begin
					want = due_rsps.pop_front();
					if (got.status !== want.status || got.victim_valid !== want.victim_valid ||
						got.victim_page !== want.victim_page ||
						got.victim_vaddr !== want.victim_vaddr) begin
						mismatches = mismatches + 1;
						if (mismatches <= 10)
							$display("response %0d: expected %0d %0b %0d %h, got %0d %0b %0d %h",
								rsp_count, want.status, want.victim_valid, want.victim_page,
								want.victim_vaddr, got.status, got.victim_valid, got.victim_page,
								got.victim_vaddr);
					end
				end
			end
			if (sink_stall > 0) begin
				sink_stall <= sink_stall - 1;
				take_ready <= 1'b0;
			end else if (fire) begin
				// One long hold-off lets the list back up and stall its request side.
				if (!long_hold_done && rsp_count >= 200) begin
					long_hold_done = 1'b1;
					n = 150;
				end else if (sink_calm > 0) begin
					sink_calm <= sink_calm - 1;
					n = 0;
				end else begin
					n = idle_len();
					if ($urandom_range(0, 49) == 0)
						sink_calm <= $urandom_range(20, 60);
				end
				if (n > 0) begin
					sink_stall <= n - 1;
					take_ready <= 1'b0;
				end else begin
					take_ready <= 1'b1;
				end
			end else begin
				take_ready <= 1'b1;
			end
		end
	end

	task automatic push_req(logic kind, lrupr_pkg::page_t page, lrupr_pkg::vaddr_t addr);
		page_req_t it;
		it.req_type = kind;
		it.page_id  = page;
		it.vaddr    = addr;
		pending_reqs.push_back(it);
	endtask

	int evict_pct = 50;
	int mix_left = 0;

	// Bursts with a changing touch/evict mix so the list fills, drains and sits full.
	task automatic queue_random(int count);
		int choice;
		lrupr_pkg::page_t page;
		repeat (count) begin
			if (mix_left == 0) begin
				choice = $urandom_range(0, 4);
				case (choice)
					0: evict_pct = 5;
					1: evict_pct = 35;
					2: evict_pct = 50;
					3: evict_pct = 65;
					default: evict_pct = 95;
				endcase
				mix_left = $urandom_range(10, 60);
			end
			mix_left--;
			if ($urandom_range(0, 9) < 8)
				page = lrupr_pkg::page_t'($urandom_range(0, 23));
			else
				page = lrupr_pkg::page_t'($urandom);
			push_req(($urandom_range(0, 99) < evict_pct) ? lrupr_pkg::REQ_EVICT
				: lrupr_pkg::REQ_TOUCH, page, lrupr_pkg::vaddr_t'({$urandom, $urandom}));
		end
	endtask

	task automatic wait_drained();
		while (pending_reqs.size() != 0 || drv_valid || due_rsps.size() != 0)
			@(negedge clk);
	endtask

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		push_req(lrupr_pkg::REQ_EVICT, '0, '0);
		push_req(lrupr_pkg::REQ_TOUCH, '0, '0);
		push_req(lrupr_pkg::REQ_TOUCH, '1, '1);
		// Touching a listed page moves it to the newest end with its new address.
		push_req(lrupr_pkg::REQ_TOUCH, '0, lrupr_pkg::vaddr_t'(39'h55_5555_5555));
		push_req(lrupr_pkg::REQ_EVICT, '1, '1);
		for (int i = 1; i <= 15; i++)
			push_req(lrupr_pkg::REQ_TOUCH, lrupr_pkg::page_t'(i * 61),
				lrupr_pkg::vaddr_t'({$urandom, $urandom}));
		push_req(lrupr_pkg::REQ_TOUCH, '1, '1);
		push_req(lrupr_pkg::REQ_TOUCH, '0, lrupr_pkg::vaddr_t'(39'h2A_AAAA_AAAA));
		push_req(lrupr_pkg::REQ_EVICT, '0, '0);
		push_req(lrupr_pkg::REQ_EVICT, '0, '0);

		queue_random(450);
		wait_drained();
		queue_random(476);
		wait_drained();
		repeat (8) @(negedge clk);

		if (mismatches == 0 && due_rsps.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		#2000000;
		$display("simulation failed");
		$finish;
	end

endmodule
